/* sv/krtr_pkg.sv */
`default_nettype none

package krtr_pkg;

  localparam int NUM_KEYS    = 64;
  localparam int NUM_BUTTONS = 8;
  localparam int NUM_CODES   = NUM_KEYS + NUM_BUTTONS;
  localparam int CODE_W      = 7;
  localparam int KEY_W       = $clog2(NUM_KEYS);
  localparam int STAMP_W     = 32;
  localparam int DELAY_W     = 16;

  localparam logic [15:0] INITIAL_DELAY_RESET   = 16'd500;
  localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd30;

  // Configuration register indexes.
  localparam logic REG_INITIAL_DELAY   = 1'b0;
  localparam logic REG_REPEAT_INTERVAL = 1'b1;

  // Input item modes.
  localparam logic [2:0] MODE_DOWN = 3'd0;
  localparam logic [2:0] MODE_UP   = 3'd1;
  localparam logic [2:0] MODE_HELD = 3'd2;
  localparam logic [2:0] MODE_TICK = 3'd3;
  localparam logic [2:0] MODE_MAP  = 3'd4;

  // Result event kinds.
  localparam logic [1:0] EV_KEY_DOWN    = 2'd0;
  localparam logic [1:0] EV_KEY_UP      = 2'd1;
  localparam logic [1:0] EV_BUTTON_DOWN = 2'd2;
  localparam logic [1:0] EV_BUTTON_UP   = 2'd3;

  // Write side of the key state memory.
  typedef struct packed {
    logic               we_held;
    logic               held;
    logic               we_stamp;
    logic [STAMP_W-1:0] stamp;
    logic               past;
    logic [KEY_W-1:0]   addr;
  } key_wr_t;

  // Registered read data of the key state memory.
  typedef struct packed {
    logic               held;
    logic [STAMP_W-1:0] stamp;
    logic               past;
  } key_rd_t;

endpackage

`default_nettype wire

/* sv/krtr_map_mem.sv */
`default_nettype none

module krtr_map_mem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        we,
  input  wire logic [krtr_pkg::CODE_W-1:0] waddr,
  input  wire logic [krtr_pkg::CODE_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [krtr_pkg::CODE_W-1:0] raddr,
  output logic      [krtr_pkg::CODE_W-1:0] rdata
);

  logic [krtr_pkg::CODE_W-1:0]    mem [krtr_pkg::NUM_CODES];
  logic [krtr_pkg::NUM_CODES-1:0] written;

  // An entry never written reads as its own index, which gives the identity map.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= written[raddr] ? mem[raddr] : raddr;
    end
  end

endmodule

`default_nettype wire

/* sv/krtr_key_mem.sv */
`default_nettype none

module krtr_key_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire krtr_pkg::key_wr_t          wr,
  input  wire logic                       re,
  input  wire logic [krtr_pkg::KEY_W-1:0] raddr,
  output krtr_pkg::key_rd_t               rd
);

  logic                         held_mem  [krtr_pkg::NUM_KEYS];
  logic [krtr_pkg::STAMP_W-1:0] stamp_mem [krtr_pkg::NUM_KEYS];
  logic                         past_mem  [krtr_pkg::NUM_KEYS];
  logic [krtr_pkg::NUM_KEYS-1:0] held_ok;
  logic [krtr_pkg::NUM_KEYS-1:0] stamp_ok;

  // The held flag and the time stamp group are written apart, so each has its
  // own written mark; an unwritten field reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_ok  <= '0;
      stamp_ok <= '0;
    end else begin
      if (wr.we_held) begin
        held_ok[wr.addr] <= 1'b1;
      end
      if (wr.we_stamp) begin
        stamp_ok[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_held) begin
      held_mem[wr.addr] <= wr.held;
    end
    if (wr.we_stamp) begin
      stamp_mem[wr.addr] <= wr.stamp;
      past_mem[wr.addr]  <= wr.past;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd.held  <= held_ok[raddr] ? held_mem[raddr] : 1'b0;
      rd.stamp <= stamp_ok[raddr] ? stamp_mem[raddr] : '0;
      rd.past  <= stamp_ok[raddr] ? past_mem[raddr] : 1'b0;
    end
  end

endmodule

`default_nettype wire

/* sv/krtr_due_unit.sv */
`default_nettype none

module krtr_due_unit (
  input  wire krtr_pkg::key_rd_t            key,
  input  wire logic [krtr_pkg::DELAY_W-1:0] initial_delay,
  input  wire logic [krtr_pkg::DELAY_W-1:0] repeat_interval,
  input  wire logic [krtr_pkg::STAMP_W-1:0] now,
  output logic                              due
);

  logic [krtr_pkg::DELAY_W-1:0] delay;
  logic [krtr_pkg::STAMP_W:0]   deadline;

  // The deadline is kept at full width, so a late stamp never wraps round.
  always_comb begin
    delay    = key.past ? repeat_interval : initial_delay;
    deadline = {1'b0, key.stamp} + (krtr_pkg::STAMP_W + 1)'(delay);
    due      = key.held && (deadline < {1'b0, now});
  end

endmodule

`default_nettype wire

/* sv/key_remap_typematic_repeat.sv */
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   mode, source_code, target_code, held, now
// out       source     out_valid / out_ready event_kind, code, is_repeat, last
// cfg       sink       cfg_write             cfg_index, cfg_data
//
// A mapping write, an unused mode and an item whose source is none or out of range are
// done when accepted; other down, up and held items then pass through ST_MAP, for the
// registered read of the code map. A tick sweeps the key state memory, which has one
// read port, one key per cycle while the output does not stall, each key's due check
// sharing one add and compare unit. A full output register holds a down or up at its
// event and the sweep at the next due key. Reset is synchronous and clears the code map
// to identity and all keys to idle at once. One item is worked on at a time.

module key_remap_typematic_repeat (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [6:0]  source_code,
  input  wire logic [6:0]  target_code,
  input  wire logic        held,
  input  wire logic [31:0] now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_kind,
  output logic [5:0]       code,
  output logic             is_repeat,
  output logic             last,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int KW = krtr_pkg::KEY_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t            state;
  logic [2:0]        mode_q;
  logic              held_q;
  logic [31:0]       now_q;
  logic [15:0]       initial_delay;
  logic [15:0]       repeat_interval;
  logic [KW:0]       rd_idx;
  logic [KW-1:0]     cmp_idx;
  logic              cmp_valid;
  logic [KW-1:0]     pend_idx;
  logic              pend_valid;

  logic              accept;
  logic              map_we;
  logic              map_re;
  logic [6:0]        map_rdata;
  logic              src_ok;
  logic              tgt_none;
  logic              tgt_key;
  krtr_pkg::key_wr_t key_wr;
  krtr_pkg::key_rd_t key_rd;
  logic              key_re;
  logic [KW-1:0]     key_raddr;
  logic              due;
  logic              rd_more;
  logic              can_push;
  logic              stall;
  logic              push;
  logic [1:0]        push_kind;
  logic [5:0]        push_code;
  logic              push_repeat;
  logic              push_last;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_push = !out_valid || out_ready;
  assign rd_more  = (rd_idx < (KW + 1)'(krtr_pkg::NUM_KEYS));
  assign src_ok   = (source_code != 7'd0) && (source_code < 7'(krtr_pkg::NUM_CODES));
  assign tgt_none = (map_rdata == 7'd0) || (map_rdata >= 7'(krtr_pkg::NUM_CODES));
  assign tgt_key  = (map_rdata < 7'(krtr_pkg::NUM_KEYS));

  assign map_we = accept && (mode == krtr_pkg::MODE_MAP)
                  && (source_code < 7'(krtr_pkg::NUM_CODES))
                  && (target_code < 7'(krtr_pkg::NUM_CODES));
  assign map_re = accept && src_ok
                  && ((mode == krtr_pkg::MODE_DOWN) || (mode == krtr_pkg::MODE_UP)
                      || (mode == krtr_pkg::MODE_HELD));

  krtr_map_mem u_map (
    .clk   (clk),
    .rst   (rst),
    .we    (map_we),
    .waddr (source_code),
    .wdata (target_code),
    .re    (map_re),
    .raddr (source_code),
    .rdata (map_rdata)
  );

  krtr_key_mem u_keys (
    .clk   (clk),
    .rst   (rst),
    .wr    (key_wr),
    .re    (key_re),
    .raddr (key_raddr),
    .rd    (key_rd)
  );

  krtr_due_unit u_due (
    .key             (key_rd),
    .initial_delay   (initial_delay),
    .repeat_interval (repeat_interval),
    .now             (now_q),
    .due             (due)
  );

  // A due key cannot be sent until the next one is found, because only then is
  // it known not to be the last; it waits in the pending register.
  assign stall = (state == ST_SCAN) && cmp_valid && due && pend_valid && !can_push;

  always_comb begin
    key_wr          = '0;
    key_wr.stamp    = now_q;
    key_wr.held     = held_q;
    key_re          = 1'b0;
    key_raddr       = rd_idx[KW-1:0];
    push            = 1'b0;
    push_kind       = krtr_pkg::EV_KEY_DOWN;
    push_code       = 6'(pend_idx);
    push_repeat     = 1'b1;
    push_last       = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_MAP: begin
        key_wr.addr = KW'(map_rdata);
        push_repeat = 1'b0;
        push_last   = 1'b1;
        if (tgt_key) begin
          push_code = 6'(map_rdata);
          push_kind = (mode_q == krtr_pkg::MODE_DOWN) ? krtr_pkg::EV_KEY_DOWN
                                                      : krtr_pkg::EV_KEY_UP;
        end else begin
          push_code = 6'(map_rdata - 7'(krtr_pkg::NUM_KEYS));
          push_kind = (mode_q == krtr_pkg::MODE_DOWN) ? krtr_pkg::EV_BUTTON_DOWN
                                                      : krtr_pkg::EV_BUTTON_UP;
        end
        if (!tgt_none) begin
          if (mode_q == krtr_pkg::MODE_HELD) begin
            key_wr.we_held = tgt_key;
          end else if (can_push) begin
            push            = 1'b1;
            key_wr.we_stamp = tgt_key && (mode_q == krtr_pkg::MODE_DOWN);
          end
        end
      end
      ST_SCAN: begin
        key_wr.addr = cmp_idx;
        key_wr.past = 1'b1;
        if (!stall) begin
          key_re          = rd_more;
          key_wr.we_stamp = cmp_valid && due;
          push            = cmp_valid && due && pend_valid;
        end
      end
      ST_FLUSH: begin
        push      = can_push;
        push_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      cmp_valid       <= 1'b0;
      pend_valid      <= 1'b0;
      initial_delay   <= krtr_pkg::INITIAL_DELAY_RESET;
      repeat_interval <= krtr_pkg::REPEAT_INTERVAL_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == krtr_pkg::REG_INITIAL_DELAY) begin
          initial_delay <= cfg_data;
        end
        if (cfg_index == krtr_pkg::REG_REPEAT_INTERVAL) begin
          repeat_interval <= cfg_data;
        end
      end

      if (push) begin
        out_valid  <= 1'b1;
        event_kind <= push_kind;
        code       <= push_code;
        is_repeat  <= push_repeat;
        last       <= push_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q <= mode;
            held_q <= held;
            now_q  <= now;
            if (map_re) begin
              state <= ST_MAP;
            end else if (mode == krtr_pkg::MODE_TICK) begin
              rd_idx     <= '0;
              cmp_valid  <= 1'b0;
              pend_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_MAP: begin
          if (tgt_none || (mode_q == krtr_pkg::MODE_HELD) || can_push) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            if (cmp_valid && due) begin
              pend_valid <= 1'b1;
              pend_idx   <= cmp_idx;
            end
            if (rd_more) begin
              cmp_idx   <= rd_idx[KW-1:0];
              cmp_valid <= 1'b1;
              rd_idx    <= rd_idx + 1'b1;
            end else begin
              cmp_valid <= 1'b0;
              if (!cmp_valid) begin
                state <= pend_valid ? ST_FLUSH : ST_IDLE;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (can_push) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
